@@ hdl/cab_pkg.sv @@
// cab_pkg: shared types, codes, reset values and blend arithmetic for the
// clipped alpha blitter. No dependencies; compiled first.
`timescale 1ns / 1ps

package cab_pkg;

	// default frame size limits
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 32;

	// short queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PARENT_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARENT_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHILD_LEFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHILD_TOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHILD_COLUMNS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHILD_ROWS    = 3'd5;

	// register reset values
	localparam logic [6:0] RST_PARENT_WIDTH  = 7'd64;
	localparam logic [5:0] RST_PARENT_HEIGHT = 6'd32;
	localparam logic [7:0] RST_CHILD_LEFT    = 8'd0;
	localparam logic [7:0] RST_CHILD_TOP     = 8'd0;
	localparam logic [7:0] RST_CHILD_COLUMNS = 8'd64;
	localparam logic [7:0] RST_CHILD_ROWS    = 8'd32;

	// input item kinds
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_BLEND   = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;
	localparam logic [1:0] KIND_RESTART = 2'd3;

	// operation handed from front to back
	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_READ,
		OP_BLEND
	} op_t;

	typedef struct packed {
		op_t  op;
		logic done;
	} ctl_t;

	// frame word layout: red in the low byte, alpha in the high byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// floor((c*a + p*(255-a)) / 255), division by 255 done as add and shift
	function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] p,
		input logic [7:0] a);
		logic [7:0]  inv_a;
		logic [15:0] prod_c;
		logic [15:0] prod_p;
		logic [16:0] sum;
		logic [16:0] q;
		inv_a  = 8'd255 - a;
		prod_c = c * a;
		prod_p = p * inv_a;
		sum    = {1'b0, prod_c} + {1'b0, prod_p};
		q      = sum + {8'd0, sum[16:8]} + 17'd1;
		return q[15:8];
	endfunction

	function automatic pixel_t blend_pixel(input pixel_t child, input pixel_t parent);
		pixel_t res;
		res.red   = mix_channel(child.red,   parent.red,   child.alpha);
		res.green = mix_channel(child.green, parent.green, child.alpha);
		res.blue  = mix_channel(child.blue,  parent.blue,  child.alpha);
		res.alpha = (child.alpha > parent.alpha) ? child.alpha : parent.alpha;
		return res;
	endfunction

endpackage

@@ hdl/cab_if.sv @@
// cab_if: valid/ready channel interfaces for commands and responses of the
// clipped alpha blitter. No dependencies.
`timescale 1ns / 1ps

interface cab_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [10:0] pixel_index;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic [7:0]  alpha_in;

	modport source(output valid, kind, pixel_index, red_in, green_in, blue_in, alpha_in,
		input ready);
	modport sink(input valid, kind, pixel_index, red_in, green_in, blue_in, alpha_in,
		output ready);
endinterface

interface cab_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic       landed;
	logic       child_done;

	modport source(output valid, red_out, green_out, blue_out, alpha_out, landed,
		child_done, input ready);
	modport sink(input valid, red_out, green_out, blue_out, alpha_out, landed,
		child_done, output ready);
endinterface

@@ hdl/cab_ram.sv @@
// cab_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps

module cab_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/cab_queue.sv @@
// cab_queue: short register fifo that decouples the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

module cab_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	assign head_data = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hdl/cab_front.sv @@
// cab_front: accepts command transfers, holds configuration and child
// position counters, clips and addresses each item. Depends on cab_pkg, cab_if.
`timescale 1ns / 1ps

module cab_front #(
	parameter int MAX_WIDTH  = cab_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cab_pkg::MAX_HEIGHT_DEF,
	parameter int ADDR_W     = (MAX_WIDTH * MAX_HEIGHT > 1) ?
		$clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	cab_cmd_if.sink                          cmd,
	input  logic                             cfg_wr_en,
	input  logic [cab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cab_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             full,
	output logic                             push,
	output cab_pkg::ctl_t                    push_ctl,
	output logic [ADDR_W-1:0]                push_addr,
	output cab_pkg::pixel_t                  push_pix
);

	import cab_pkg::*;

	localparam int FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int W_CAP       = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
	localparam int H_CAP       = (MAX_HEIGHT < 63) ? MAX_HEIGHT : 63;
	localparam logic [16:0] FRAME_LIM = 17'(FRAME_WORDS);

	logic [6:0] parent_width_q;
	logic [5:0] parent_height_q;
	logic [7:0] child_left_q;
	logic [7:0] child_top_q;
	logic [7:0] child_columns_q;
	logic [7:0] child_rows_q;
	logic [7:0] col_q;
	logic [7:0] row_q;

	logic [6:0]  w;
	logic [5:0]  h;
	logic [9:0]  px;
	logic [9:0]  py;
	logic        x_in;
	logic        y_in;
	logic [12:0] prod;
	logic [13:0] idx;
	logic [8:0]  col_inc;
	logic [8:0]  row_inc;
	logic        col_wrap;
	logic        row_wrap;
	logic        addr_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_width_q  <= RST_PARENT_WIDTH;
			parent_height_q <= RST_PARENT_HEIGHT;
			child_left_q    <= RST_CHILD_LEFT;
			child_top_q     <= RST_CHILD_TOP;
			child_columns_q <= RST_CHILD_COLUMNS;
			child_rows_q    <= RST_CHILD_ROWS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PARENT_WIDTH:  parent_width_q  <= cfg_data[6:0];
				REG_PARENT_HEIGHT: parent_height_q <= cfg_data[5:0];
				REG_CHILD_LEFT:    child_left_q    <= cfg_data;
				REG_CHILD_TOP:     child_top_q     <= cfg_data;
				REG_CHILD_COLUMNS: child_columns_q <= cfg_data;
				REG_CHILD_ROWS:    child_rows_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// saturated parent size and child pixel position
	always_comb begin
		w    = (parent_width_q > 7'(W_CAP)) ? 7'(W_CAP) : parent_width_q;
		h    = (parent_height_q > 6'(H_CAP)) ? 6'(H_CAP) : parent_height_q;
		px   = {{2{child_left_q[7]}}, child_left_q} + {2'b00, col_q};
		py   = {{2{child_top_q[7]}}, child_top_q} + {2'b00, row_q};
		x_in = !px[9] && (px[8:0] < {2'b00, w});
		y_in = !py[9] && (py[8:0] < {3'b000, h});
		prod = py[5:0] * w;
		idx  = {1'b0, prod} + {7'd0, px[6:0]};
	end

	// raster counter wrap
	always_comb begin
		col_inc  = {1'b0, col_q} + 9'd1;
		row_inc  = {1'b0, row_q} + 9'd1;
		col_wrap = (col_inc >= {1'b0, child_columns_q});
		row_wrap = (row_inc >= {1'b0, child_rows_q});
	end

	assign addr_ok   = ({6'd0, cmd.pixel_index} < FRAME_LIM);
	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	// classify the item for the back part
	always_comb begin
		push_ctl.op    = OP_NONE;
		push_ctl.done  = 1'b0;
		push_addr      = ADDR_W'(cmd.pixel_index);
		push_pix.red   = cmd.red_in;
		push_pix.green = cmd.green_in;
		push_pix.blue  = cmd.blue_in;
		push_pix.alpha = cmd.alpha_in;
		case (cmd.kind)
			KIND_LOAD: begin
				if (addr_ok) begin
					push_ctl.op = OP_LOAD;
				end
			end
			KIND_READ: begin
				if (addr_ok) begin
					push_ctl.op = OP_READ;
				end
			end
			KIND_BLEND: begin
				push_ctl.done = col_wrap && row_wrap;
				push_addr     = ADDR_W'(idx);
				if (x_in && y_in) begin
					push_ctl.op = OP_BLEND;
				end
			end
			default: begin
			end
		endcase
	end

	// child position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (cmd.kind == KIND_RESTART) begin
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.kind == KIND_BLEND) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[7:0];
				end else begin
					col_q <= col_inc[7:0];
				end
			end
		end
	end

endmodule

@@ hdl/cab_back.sv @@
// cab_back: frame memory read-modify-write, blend datapath and response
// register. Depends on cab_pkg, cab_if and cab_ram.
`timescale 1ns / 1ps

module cab_back #(
	parameter int DEPTH  = cab_pkg::MAX_WIDTH_DEF * cab_pkg::MAX_HEIGHT_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  cab_pkg::ctl_t     head_ctl,
	input  logic [ADDR_W-1:0] head_addr,
	input  cab_pkg::pixel_t   head_pix,
	output logic              pop,
	cab_rsp_if.source         rsp
);

	import cab_pkg::*;

	logic              adv;
	logic [31:0]       ram_rd_data;
	logic              wr_en;
	logic              wr_req;
	logic              landed;

	logic              vld_s1;
	ctl_t              ctl_s1;
	logic [ADDR_W-1:0] addr_s1;
	pixel_t            pix_s1;

	logic              fwd_vld_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	pixel_t            fwd_pix_q;

	logic              out_vld_q;
	pixel_t            out_pix_q;
	logic              out_landed_q;
	logic              out_done_q;

	pixel_t            base;
	pixel_t            mixed;
	pixel_t            res;

	// whole back part moves when the response register can take a new item
	assign adv = !out_vld_q || rsp.ready;
	assign pop = adv && !empty;

	cab_ram #(
		.WIDTH ($bits(pixel_t)),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_frame (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(res),
		.rd_en  (pop),
		.rd_addr(head_addr),
		.rd_data(ram_rd_data)
	);

	// parent pixel, bypassing the write that landed with this read
	assign base  = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_pix_q : pixel_t'(ram_rd_data);
	assign mixed = blend_pixel(pix_s1, base);

	// result per operation
	always_comb begin
		res    = '0;
		wr_req = 1'b0;
		landed = 1'b0;
		case (ctl_s1.op)
			OP_LOAD: begin
				res    = pix_s1;
				wr_req = 1'b1;
			end
			OP_READ: begin
				res = base;
			end
			OP_BLEND: begin
				res    = mixed;
				wr_req = 1'b1;
				landed = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign wr_en = adv && vld_s1 && wr_req;

	// stage valids and bypass valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= pop;
			fwd_vld_q <= wr_en;
			out_vld_q <= vld_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1       <= head_ctl;
			addr_s1      <= head_addr;
			pix_s1       <= head_pix;
			fwd_addr_q   <= addr_s1;
			fwd_pix_q    <= res;
			out_pix_q    <= res;
			out_landed_q <= landed;
			out_done_q   <= ctl_s1.done;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.red_out    = out_pix_q.red;
	assign rsp.green_out  = out_pix_q.green;
	assign rsp.blue_out   = out_pix_q.blue;
	assign rsp.alpha_out  = out_pix_q.alpha;
	assign rsp.landed     = out_landed_q;
	assign rsp.child_done = out_done_q;

endmodule

@@ hdl/clipped_alpha_blit.sv @@
// clipped_alpha_blit: alpha blitter of streamed child pixels into a parent frame.
// Commands pass the queue, frame read and response register. Throughput: one item
// per cycle unless rsp stalls, set by one frame memory read and one write per cycle.
// A write followed at once by a read of the same pixel is bypassed, so no stall.
// Reset clears counters, queue and pipeline, configuration goes to its defaults;
// frame contents are undefined until loaded.
`timescale 1ns / 1ps

module clipped_alpha_blit #(
	parameter int MAX_WIDTH  = cab_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cab_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cab_cmd_if.sink                        cmd,
	cab_rsp_if.source                      rsp,
	input  logic                           cfg_wr_en,
	input  logic [cab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cab_pkg::CFG_DATA_W-1:0] cfg_data
);

	import cab_pkg::*;

	localparam int FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int ENTRY_W     = $bits(ctl_t) + ADDR_W + $bits(pixel_t);

	logic              push;
	ctl_t              push_ctl;
	logic [ADDR_W-1:0] push_addr;
	pixel_t            push_pix;
	logic              pop;
	logic              full;
	logic              empty;
	logic [ENTRY_W-1:0] head_entry;
	ctl_t              head_ctl;
	logic [ADDR_W-1:0] head_addr;
	pixel_t            head_pix;

	cab_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.ADDR_W    (ADDR_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.full     (full),
		.push     (push),
		.push_ctl (push_ctl),
		.push_addr(push_addr),
		.push_pix (push_pix)
	);

	cab_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctl, push_addr, push_pix}),
		.pop      (pop),
		.head_data(head_entry),
		.full     (full),
		.empty    (empty)
	);

	// unpack queue head
	assign {head_ctl, head_addr, head_pix} = head_entry;

	cab_back #(
		.DEPTH (FRAME_WORDS),
		.ADDR_W(ADDR_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head_ctl (head_ctl),
		.head_addr(head_addr),
		.head_pix (head_pix),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

@@ tb/sv/clipped_alpha_blit_test.sv @@
// clipped_alpha_blit_test: self-checking bench for the clipped alpha blitter; a scoreboard
// predicts every response from its own frame copy, counters and register shadow.
// Depends on cab_pkg and the cab_cmd_if / cab_rsp_if channel interfaces.
`timescale 1ns / 1ps

module clipped_alpha_blit_test;
	import cab_pkg::*;

	localparam int FRAME_W     = MAX_WIDTH_DEF;
	localparam int FRAME_H     = MAX_HEIGHT_DEF;
	localparam int FRAME_WORDS = FRAME_W * FRAME_H;
	localparam int DRAIN_SLACK = 6;
	localparam int LONG_HOLD   = 150;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] pixel_index;
		pixel_t      pix;
	} blit_cmd_t;

	typedef struct packed {
		pixel_t pix;
		logic   landed;
		logic   child_done;
	} blit_rsp_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cab_cmd_if cmd_bus();
	cab_rsp_if rsp_bus();

	clipped_alpha_blit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_bus),
		.rsp       (rsp_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// scoreboard copy of the frame, child position and registers
	pixel_t            frame [FRAME_WORDS];
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [6:0]        cfg_width;
	logic [5:0]        cfg_height;
	logic signed [7:0] cfg_left;
	logic signed [7:0] cfg_top;
	logic [7:0]        cfg_columns;
	logic [7:0]        cfg_rows;

	// stimulus bookkeeping: frame entries that hold loaded data
	bit        loaded [FRAME_WORDS];
	int        loaded_addrs[$];
	blit_cmd_t pending_cmds[$];
	blit_rsp_t pixels_due[$];
	bit        offering;

	int send_idle_pct;
	int recv_idle_pct;
	int holds_requested;
	int holds_served;
	int hold_left;

	int mismatches;
	int results_checked;
	int landed_count;
	int done_count;
	int kind_count [4];

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_size(input int v, input int lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [7:0] over_channel(input int c, input int p, input int a);
		return 8'((c * a + p * (255 - a)) / 255);
	endfunction

	function automatic pixel_t rgba(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		pixel_t px;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		px.alpha = a;
		return px;
	endfunction

	// apply one transfer to the frame copy and return the response it causes
	function automatic blit_rsp_t blit_into_frame(input blit_cmd_t c);
		blit_rsp_t   r;
		pixel_t      p;
		int          w, h, px, py, idx;
		int unsigned nc, nr;
		r = '0;
		case (c.kind)
			KIND_LOAD: begin
				frame[c.pixel_index] = c.pix;
				r.pix = c.pix;
			end
			KIND_READ: r.pix = frame[c.pixel_index];
			KIND_RESTART: begin
				col_pos = 0;
				row_pos = 0;
			end
			default: begin
				w  = eff_size(cfg_width, FRAME_W);
				h  = eff_size(cfg_height, FRAME_H);
				px = int'(cfg_left) + int'(col_pos);
				py = int'(cfg_top) + int'(row_pos);
				// clip against the parent, then blend over the stored pixel
				if (px >= 0 && py >= 0 && px < w && py < h) begin
					idx = py * w + px;
					p = frame[idx];
					r.pix.red   = over_channel(c.pix.red, p.red, c.pix.alpha);
					r.pix.green = over_channel(c.pix.green, p.green, c.pix.alpha);
					r.pix.blue  = over_channel(c.pix.blue, p.blue, c.pix.alpha);
					r.pix.alpha = (c.pix.alpha > p.alpha) ? c.pix.alpha : p.alpha;
					frame[idx] = r.pix;
					r.landed = 1'b1;
				end
				// raster advance, a zero count behaves like one
				nc = col_pos + 1;
				nr = row_pos;
				if (nc >= cfg_columns) begin
					nc = 0;
					nr = row_pos + 1;
					if (nr >= cfg_rows) begin
						nr = 0;
						r.child_done = 1'b1;
					end
				end
				col_pos = nc % 256;
				row_pos = nr % 256;
			end
		endcase
		return r;
	endfunction

	function automatic pixel_t rand_pixel();
		int     sel;
		pixel_t px;
		sel = $urandom_range(0, 7);
		px = rgba(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		if (sel == 0)
			px.alpha = 8'd0;
		else if (sel == 1)
			px.alpha = 8'd255;
		return px;
	endfunction

	function automatic logic [10:0] pick_loaded();
		return 11'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
	endfunction

	task automatic queue_item(input logic [1:0] kind, input logic [10:0] addr,
		input pixel_t pix);
		blit_cmd_t c;
		c.kind        = kind;
		c.pixel_index = addr;
		c.pix         = pix;
		if (kind == KIND_LOAD && !loaded[addr]) begin
			loaded[addr] = 1'b1;
			loaded_addrs.insert(loaded_addrs.size(), int'(addr));
		end
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// mostly child pixels, with loads, reads and restarts mixed in
	task automatic queue_random_item(input int restart_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < restart_pct)
			queue_item(KIND_RESTART, 11'($urandom), rand_pixel());
		else if (roll < restart_pct + 10)
			queue_item(KIND_LOAD, 11'($urandom), rand_pixel());
		else if (roll < restart_pct + 20)
			queue_item(KIND_READ, pick_loaded(), rand_pixel());
		else
			queue_item(KIND_BLEND, 11'($urandom), rand_pixel());
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || offering || pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	// reprogram while idle, load the reachable parent area, then stream
	task automatic run_phase(input logic [6:0] w_set, input logic [5:0] h_set,
		input logic signed [7:0] left_set, input logic signed [7:0] top_set,
		input logic [7:0] cols_set, input logic [7:0] rows_set, input int n_items,
		input int restart_pct, input bit pause_midway, input bit hold_receiver);
		int area;
		int i;
		wait_drained();
		write_reg(REG_PARENT_WIDTH, {1'b0, w_set});
		write_reg(REG_PARENT_HEIGHT, {2'b00, h_set});
		write_reg(REG_CHILD_LEFT, left_set);
		write_reg(REG_CHILD_TOP, top_set);
		write_reg(REG_CHILD_COLUMNS, cols_set);
		write_reg(REG_CHILD_ROWS, rows_set);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		cfg_width   = w_set;
		cfg_height  = h_set;
		cfg_left    = left_set;
		cfg_top     = top_set;
		cfg_columns = cols_set;
		cfg_rows    = rows_set;
		area = eff_size(w_set, FRAME_W) * eff_size(h_set, FRAME_H);
		for (i = 0; i < area; i++)
			if (!loaded[i])
				queue_item(KIND_LOAD, 11'(i), rand_pixel());
		for (i = 0; i < n_items; i++) begin
			// sender goes quiet until every response is back
			if (pause_midway && i == n_items / 2)
				wait_drained();
			queue_random_item(restart_pct);
		end
		if (hold_receiver)
			holds_requested++;
	endtask

	// command driver: a transfer stays offered until it is taken
	always @(negedge clk) begin
		if (arst_n && !offering) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cmd_bus.valid       <= 1'b1;
				cmd_bus.kind        <= pending_cmds[0].kind;
				cmd_bus.pixel_index <= pending_cmds[0].pixel_index;
				cmd_bus.red_in      <= pending_cmds[0].pix.red;
				cmd_bus.green_in    <= pending_cmds[0].pix.green;
				cmd_bus.blue_in     <= pending_cmds[0].pix.blue;
				cmd_bus.alpha_in    <= pending_cmds[0].pix.alpha;
				offering = 1'b1;
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// command transfer: predict its response
	always @(posedge clk) begin
		blit_cmd_t item;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			item = pending_cmds.pop_front();
			kind_count[item.kind]++;
			pixels_due.insert(pixels_due.size(), blit_into_frame(item));
			offering = 1'b0;
		end
	end

	// response ready: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (holds_served != holds_requested) begin
				hold_left = LONG_HOLD;
				holds_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// response transfer: compare with the oldest prediction
	always @(posedge clk) begin
		blit_rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: stray response, expected none, actual %0h %0h %0h %0h %0b %0b",
						$time, rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out,
						rsp_bus.alpha_out, rsp_bus.landed, rsp_bus.child_done);
			end else begin
				want = pixels_due.pop_front();
				check_field("red_out", want.pix.red, rsp_bus.red_out);
				check_field("green_out", want.pix.green, rsp_bus.green_out);
				check_field("blue_out", want.pix.blue, rsp_bus.blue_out);
				check_field("alpha_out", want.pix.alpha, rsp_bus.alpha_out);
				check_field("landed", 8'(want.landed), 8'(rsp_bus.landed));
				check_field("child_done", 8'(want.child_done), 8'(rsp_bus.child_done));
				results_checked++;
				landed_count += want.landed;
				done_count += want.child_done;
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d responses outstanding", pixels_due.size());
		$display("TEST FAILED");
		$finish;
	end

	// stimulus sequence
	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.kind        = KIND_LOAD;
		cmd_bus.pixel_index = '0;
		cmd_bus.red_in      = '0;
		cmd_bus.green_in    = '0;
		cmd_bus.blue_in     = '0;
		cmd_bus.alpha_in    = '0;
		rsp_bus.ready       = 1'b0;
		offering            = 1'b0;
		col_pos             = 0;
		row_pos             = 0;
		cfg_width           = RST_PARENT_WIDTH;
		cfg_height          = RST_PARENT_HEIGHT;
		cfg_left            = RST_CHILD_LEFT;
		cfg_top             = RST_CHILD_TOP;
		cfg_columns         = RST_CHILD_COLUMNS;
		cfg_rows            = RST_CHILD_ROWS;
		send_idle_pct       = 22;
		recv_idle_pct       = 58;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extreme pixels and addresses at the reset settings
		queue_item(KIND_LOAD, 11'd0, rgba(8'h00, 8'h00, 8'h00, 8'h00));
		queue_item(KIND_LOAD, 11'd1, rgba(8'hff, 8'hff, 8'hff, 8'hff));
		queue_item(KIND_LOAD, 11'd2, rgba(8'h55, 8'haa, 8'h55, 8'h80));
		queue_item(KIND_LOAD, 11'd3, rgba(8'haa, 8'h55, 8'haa, 8'h55));
		queue_item(KIND_LOAD, 11'd1024, rgba(8'h55, 8'h55, 8'h55, 8'h55));
		queue_item(KIND_LOAD, 11'd2047, rgba(8'hff, 8'h00, 8'hff, 8'h00));
		queue_item(KIND_READ, 11'd2047, rgba(8'h00, 8'h00, 8'h00, 8'h00));
		queue_item(KIND_READ, 11'd1024, rgba(8'hff, 8'hff, 8'hff, 8'hff));
		// opaque child, transparent child, lower and higher child alpha
		queue_item(KIND_BLEND, 11'd0, rgba(8'hff, 8'hff, 8'hff, 8'hff));
		queue_item(KIND_BLEND, 11'd0, rgba(8'h00, 8'h00, 8'h00, 8'h00));
		queue_item(KIND_BLEND, 11'd0, rgba(8'haa, 8'h55, 8'haa, 8'h40));
		queue_item(KIND_BLEND, 11'd0, rgba(8'h55, 8'haa, 8'h55, 8'hc0));
		queue_item(KIND_READ, 11'd0, rand_pixel());
		queue_item(KIND_READ, 11'd1, rand_pixel());
		queue_item(KIND_READ, 11'd2, rand_pixel());
		queue_item(KIND_READ, 11'd3, rand_pixel());
		// restart puts the next child pixel back on the origin
		queue_item(KIND_RESTART, 11'd0, rand_pixel());
		queue_item(KIND_BLEND, 11'd0, rgba(8'h12, 8'hed, 8'h7f, 8'h7f));
		queue_item(KIND_READ, 11'd0, rand_pixel());

		// sender lightly idle, receiver mostly stalled
		run_phase(7'd8, 6'd4, 8'sd0, 8'sd0, 8'd8, 8'd4, 100, 3, 1'b0, 1'b0);
		run_phase(7'd64, 6'd2, -8'sd3, -8'sd1, 8'd70, 8'd4, 100, 3, 1'b1, 1'b0);
		// oversized width saturates, widest child wraps its column
		run_phase(7'd127, 6'd1, 8'sd60, 8'sd0, 8'd255, 8'd1, 330, 0, 1'b0, 1'b0);

		// sender mostly idle, receiver lightly stalled
		wait_drained();
		send_idle_pct = 58;
		recv_idle_pct = 22;
		run_phase(7'd1, 6'd32, 8'sd0, -8'sd128, 8'd1, 8'd160, 220, 0, 1'b0, 1'b0);
		// zero parent sizes skip everything, zero counts act like one
		run_phase(7'd0, 6'd32, 8'sd127, 8'sd127, 8'd0, 8'd0, 40, 4, 1'b0, 1'b0);
		run_phase(7'd5, 6'd0, -8'sd128, -8'sd128, 8'd3, 8'd2, 40, 4, 1'b0, 1'b0);

		// no idling; long receiver hold-off backs up the input
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(7'd16, 6'd8, -8'sd2, 8'sd1, 8'd20, 8'd12, 100, 3, 1'b0, 1'b1);
		// counts shrink below the current position
		run_phase(7'd16, 6'd8, 8'sd5, -8'sd1, 8'd3, 8'd2, 80, 3, 1'b1, 1'b0);
		// oversized height saturates
		run_phase(7'd2, 6'd50, -8'sd1, 8'sd20, 8'd4, 8'd20, 60, 3, 1'b0, 1'b0);
		repeat (3)
			run_phase(7'($urandom_range(1, 12)), 6'($urandom_range(1, 12)),
				8'($urandom_range(0, 40) - 20), 8'($urandom_range(0, 40) - 20),
				8'($urandom_range(1, 24)), 8'($urandom_range(1, 16)), 50, 4, 1'b0, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("transfers: %0d loads, %0d child pixels, %0d reads, %0d restarts",
			kind_count[KIND_LOAD], kind_count[KIND_BLEND], kind_count[KIND_READ],
			kind_count[KIND_RESTART]);
		$display("responses: %0d checked, %0d landed, %0d child images done, %0d mismatches",
			results_checked, landed_count, done_count, mismatches);
		if (mismatches == 0 && pixels_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
